// ===== src/belt_cts_pkg.sv =====
// ----------------------------------------------------------------------------
// belt_cts_pkg
// Shared constants and functions for the BelT CBC ciphertext stealing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package belt_cts_pkg;

    localparam int BLK_BYTES = 16;
    localparam int BLK_W     = 8 * BLK_BYTES;
    localparam int KEY_W     = 256;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd6;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BLK_BYTES);

    localparam logic [7:0] SBOX [0:255] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    function automatic logic [31:0] bswap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] belt_g(input logic [31:0] u, input int unsigned r);
        logic [31:0] s;
        s = {SBOX[u[31:24]], SBOX[u[23:16]], SBOX[u[15:8]], SBOX[u[7:0]]};
        return (s << r) | (s >> (32 - r));
    endfunction

    function automatic logic [BLK_W-1:0] keep_mask(input logic [CNT_W-1:0] n);
        return ~({BLK_W{1'b1}} >> ({3'd0, n} * 8));
    endfunction

endpackage

`default_nettype wire

// ===== src/belt_cts_cipher.sv =====
// ----------------------------------------------------------------------------
// belt_cts_cipher
// BelT block cipher, eight unrolled rounds, combinational encrypt or decrypt.
// ----------------------------------------------------------------------------
`default_nettype none

module belt_cts_cipher (
    input  wire logic [belt_cts_pkg::KEY_W-1:0] key,
    input  wire logic [belt_cts_pkg::BLK_W-1:0] blk_in,
    input  wire logic                           dec,
    output logic      [belt_cts_pkg::BLK_W-1:0] blk_out
);
    import belt_cts_pkg::*;

    logic [31:0] k [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            k[i] = bswap32(key[KEY_W-1-32*i -: 32]);
        end
    end

    always_comb
    begin
        logic [31:0] a, b, c, d, e, t;
        a = bswap32(blk_in[127:96]);
        b = bswap32(blk_in[95:64]);
        c = bswap32(blk_in[63:32]);
        d = bswap32(blk_in[31:0]);
        if (!dec)
        begin
            for (int i = 0; i < 8; i++)
            begin
                b = b ^ belt_g(a + k[3'(7*i)], 5);
                c = c ^ belt_g(d + k[3'(7*i+1)], 21);
                a = a - belt_g(b + k[3'(7*i+2)], 13);
                e = belt_g(b + c + k[3'(7*i+3)], 21) ^ 32'(i + 1);
                b = b + e;
                c = c - e;
                d = d + belt_g(c + k[3'(7*i+4)], 13);
                b = b ^ belt_g(a + k[3'(7*i+5)], 21);
                c = c ^ belt_g(d + k[3'(7*i+6)], 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = b; b = c; c = t;
            end
            blk_out = {bswap32(b), bswap32(d), bswap32(a), bswap32(c)};
        end
        else
        begin
            for (int i = 8; i >= 1; i--)
            begin
                b = b ^ belt_g(a + k[3'(7*(i-1)+6)], 5);
                c = c ^ belt_g(d + k[3'(7*(i-1)+5)], 21);
                a = a - belt_g(b + k[3'(7*(i-1)+4)], 13);
                e = belt_g(b + c + k[3'(7*(i-1)+3)], 21) ^ 32'(i);
                b = b + e;
                c = c - e;
                d = d + belt_g(c + k[3'(7*(i-1)+2)], 13);
                b = b ^ belt_g(a + k[3'(7*(i-1)+1)], 21);
                c = c ^ belt_g(d + k[3'(7*(i-1))], 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = a; a = d; d = t;
            end
            blk_out = {bswap32(c), bswap32(a), bswap32(d), bswap32(b)};
        end
    end

endmodule

`default_nettype wire

// ===== src/belt_cbc_cts_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// belt_cbc_cts_cipher_unit
// BelT CBC mode with ciphertext stealing, one 16-byte block per transaction.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in         in_valid/in_ready     data_high, data_low, byte_count,
//                                             last_block
//   out      out        out_valid/out_ready   result_high, result_low,
//                                             result_bytes, end_of_message, error
//
// One cipher pass per cycle through the unrolled round logic; a new
// transaction is taken every cycle unless the input stalls as below.
// A full last block with a block pending closes in S_FULL2; a short last
// block with a block pending takes two cipher passes and a tail.
// Results sit in one output register; input stalls while it is full and
// not taken, and during the later steps of a closing block.
// Reset clears pending state and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module belt_cbc_cts_cipher_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [belt_cts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [63:0]                        data_high,
    input  wire logic [63:0]                        data_low,
    input  wire logic [belt_cts_pkg::CNT_W-1:0]     byte_count,
    input  wire logic                               last_block,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [63:0]                             result_high,
    output logic [63:0]                             result_low,
    output logic [belt_cts_pkg::CNT_W-1:0]          result_bytes,
    output logic                                    end_of_message,
    output logic                                    error
);
    import belt_cts_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FULL2, S_ENC2, S_DEC2, S_TAIL} state_t;

    state_t              state_reg, state_next;
    logic [KEY_W-1:0]    key_reg;
    logic [BLK_W-1:0]    iv_reg;
    logic                dec_reg;
    logic [BLK_W-1:0]    chain_reg, chain_next;
    logic [BLK_W-1:0]    pend_reg, pend_next;
    logic                pv_reg, pv_next;
    logic [BLK_W-1:0]    x_reg, x_next;
    logic [BLK_W-1:0]    sv_reg, sv_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                out_valid_reg, out_valid_next;
    logic [BLK_W-1:0]    res_reg, res_next;
    logic [CNT_W-1:0]    rbytes_reg, rbytes_next;
    logic                eom_reg, eom_next;
    logic                err_reg, err_next;

    logic                go, accept;
    logic [CNT_W-1:0]    n_eff;
    logic [BLK_W-1:0]    x_in, cv, src, c_in, c_out;
    logic                c_dec;

    assign cfg_ready = 1'b1;
    assign go        = !out_valid_reg || out_ready;
    assign in_ready  = go && (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    assign n_eff = (!last_block || byte_count == '0 || byte_count > FULL_COUNT)
                   ? FULL_COUNT : byte_count;
    assign x_in  = {data_high, data_low} & keep_mask(n_eff);
    assign cv    = pv_reg ? chain_reg : iv_reg;

    belt_cts_cipher u_cipher (
        .key     (key_reg),
        .blk_in  (c_in),
        .dec     (c_dec),
        .blk_out (c_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        pend_next      = pend_reg;
        pv_next        = pv_reg;
        x_next         = x_reg;
        sv_next        = sv_reg;
        n_next         = n_reg;
        out_valid_next = go ? 1'b0 : out_valid_reg;
        res_next       = res_reg;
        rbytes_next    = rbytes_reg;
        eom_next       = eom_reg;
        err_next       = err_reg;
        c_dec          = dec_reg;
        src            = (last_block && !pv_reg) ? x_in : pend_reg;
        c_in           = dec_reg ? src : (src ^ cv);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next = x_in;
                    n_next = n_eff;
                    if (!last_block)
                    begin
                        pend_next  = x_in;
                        pv_next    = 1'b1;
                        chain_next = pv_reg ? (dec_reg ? src : c_out) : cv;
                        if (pv_reg)
                        begin
                            out_valid_next = 1'b1;
                            res_next       = dec_reg ? (c_out ^ cv) : c_out;
                            rbytes_next    = FULL_COUNT;
                            eom_next       = 1'b0;
                            err_next       = 1'b0;
                        end
                    end
                    else if (!pv_reg)
                    begin
                        out_valid_next = 1'b1;
                        eom_next       = 1'b1;
                        if (n_eff == FULL_COUNT)
                        begin
                            res_next    = dec_reg ? (c_out ^ cv) : c_out;
                            rbytes_next = FULL_COUNT;
                            err_next    = 1'b0;
                        end
                        else
                        begin
                            res_next    = '0;
                            rbytes_next = '0;
                            err_next    = 1'b1;
                        end
                    end
                    else if (n_eff == FULL_COUNT)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = dec_reg ? (c_out ^ cv) : c_out;
                        rbytes_next    = FULL_COUNT;
                        eom_next       = 1'b0;
                        err_next       = 1'b0;
                        chain_next     = dec_reg ? src : c_out;
                        state_next     = S_FULL2;
                    end
                    else
                    begin
                        chain_next = cv;
                        sv_next    = dec_reg ? (c_out ^ x_in) : c_out;
                        state_next = dec_reg ? S_DEC2 : S_ENC2;
                    end
                end
            end
            S_FULL2:
            begin
                c_in = dec_reg ? x_reg : (x_reg ^ chain_reg);
                if (go)
                begin
                    out_valid_next = 1'b1;
                    res_next       = dec_reg ? (c_out ^ chain_reg) : c_out;
                    rbytes_next    = FULL_COUNT;
                    eom_next       = 1'b1;
                    err_next       = 1'b0;
                    pv_next        = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_ENC2:
            begin
                c_dec = 1'b0;
                c_in  = sv_reg ^ x_reg;
                if (go)
                begin
                    out_valid_next = 1'b1;
                    res_next       = c_out;
                    rbytes_next    = FULL_COUNT;
                    eom_next       = 1'b0;
                    err_next       = 1'b0;
                    state_next     = S_TAIL;
                end
            end
            S_DEC2:
            begin
                c_dec = 1'b1;
                c_in  = (x_reg & keep_mask(n_reg)) | (sv_reg & ~keep_mask(n_reg));
                if (go)
                begin
                    out_valid_next = 1'b1;
                    res_next       = c_out ^ chain_reg;
                    rbytes_next    = FULL_COUNT;
                    eom_next       = 1'b0;
                    err_next       = 1'b0;
                    state_next     = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (go)
                begin
                    out_valid_next = 1'b1;
                    res_next       = sv_reg & keep_mask(n_reg);
                    rbytes_next    = n_reg;
                    eom_next       = 1'b1;
                    err_next       = 1'b0;
                    pv_next        = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            iv_reg        <= '0;
            dec_reg       <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_KEY_0:   key_reg[255:192] <= cfg_data;
                    CFG_KEY_1:   key_reg[191:128] <= cfg_data;
                    CFG_KEY_2:   key_reg[127:64]  <= cfg_data;
                    CFG_KEY_3:   key_reg[63:0]    <= cfg_data;
                    CFG_IV_HIGH: iv_reg[127:64]   <= cfg_data;
                    CFG_IV_LOW:  iv_reg[63:0]     <= cfg_data;
                    CFG_DECRYPT: dec_reg          <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        x_reg      <= x_next;
        sv_reg     <= sv_next;
        n_reg      <= n_next;
        res_reg    <= res_next;
        rbytes_reg <= rbytes_next;
        eom_reg    <= eom_next;
        err_reg    <= err_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_high    = res_reg[127:64];
    assign result_low     = res_reg[63:0];
    assign result_bytes   = rbytes_reg;
    assign end_of_message = eom_reg;
    assign error          = err_reg;

    a_err_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (end_of_message && result_bytes == '0))
        else $error("error result without end of message");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken during multi-cycle step");

    a_tail_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL || state_reg == S_FULL2) |-> pv_reg)
        else $error("closing step without pending block");

    a_tail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL && go) |=> (out_valid && end_of_message))
        else $error("tail step lost its result");

endmodule

`default_nettype wire
